FILE: src/ststs_pkg.sv
package ststs_pkg;

	localparam int KEY_W = 64;

	// Action codes.
	localparam logic [3:0] ACT_INSERT   = 4'd0;
	localparam logic [3:0] ACT_REMOVE   = 4'd1;
	localparam logic [3:0] ACT_CONTAINS = 4'd2;
	localparam logic [3:0] ACT_SUCC     = 4'd3;
	localparam logic [3:0] ACT_PRED     = 4'd4;
	localparam logic [3:0] ACT_RANK     = 4'd5;
	localparam logic [3:0] ACT_FIRST    = 4'd6;
	localparam logic [3:0] ACT_LAST     = 4'd7;
	localparam logic [3:0] ACT_RIDX     = 4'd8;
	localparam logic [3:0] ACT_RKEYS    = 4'd9;

	// Status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// Most entries emitted by one range read.
	localparam int MAX_RESULTS = 32;

	typedef struct packed {
		logic [3:0]              action;
		logic signed [KEY_W-1:0] key;
		logic signed [KEY_W-1:0] end_key;
		logic [5:0]              start_index;
		logic [5:0]              end_index;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [KEY_W-1:0] value;
		logic [4:0]              position;
		logic [5:0]              count;
		logic                    last_item;
	} rsp_t;

endpackage

FILE: src/ststs_ram.sv
module ststs_ram #(
	parameter int DEPTH = 32
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  logic [ststs_pkg::KEY_W-1:0]      wr_data,
	input  logic                             rd_en,
	input  logic [$clog2(DEPTH)-1:0]         rd_addr,
	output logic [ststs_pkg::KEY_W-1:0]      rd_data
);

	logic [ststs_pkg::KEY_W-1:0] mem_q [DEPTH];

	// One write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// One registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: src/sorted_timestamp_set_unit.sv
// Sorted set of up to CAPACITY distinct signed 64-bit timestamps kept in one memory.
// Each item first runs a binary search of up to P = ceil(log2(count+1)) probes;
// each probe reads, then compares; a memory read adds the read-and-emit stage.
// Insert/remove read and write each shifted entry; range reads emit one entry per cycle,
// and range by keys runs two searches. One item at a time: busy holds until the last result.
// The receiver cannot stall. Reset clears the entry count and control state, not the memory.
module sorted_timestamp_set_unit #(
	parameter int CAPACITY = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ststs_pkg::req_t   request,
	output logic              busy,
	output logic              result_valid,
	output ststs_pkg::rsp_t   result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > 6) ? CW : 6;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_SRD    = 10'b0000000010,
		S_SCMP   = 10'b0000000100,
		S_DISP   = 10'b0000001000,
		S_INS_RD = 10'b0000010000,
		S_INS_WR = 10'b0000100000,
		S_REM_RD = 10'b0001000000,
		S_REM_WR = 10'b0010000000,
		S_RANGE  = 10'b0100000000,
		S_SPARE  = 10'b1000000000
	} state_t;

	state_t          state_q;
	ststs_pkg::req_t req_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   lo_q;
	logic [CW-1:0]   hi_q;
	logic [CW-1:0]   mid_q;
	logic            found_q;
	logic            pass_q;
	logic [EW-1:0]   rs_q;
	logic [EW-1:0]   re_q;
	logic [CW-1:0]   i_q;
	logic [CW-1:0]   stop_q;
	logic [5:0]      n_q;

	logic            pend_s1;
	logic [CW-1:0]   pos_s1;
	logic            last_s1;

	logic            out_v_q;
	ststs_pkg::rsp_t out_q;

	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [ststs_pkg::KEY_W-1:0]   wr_data;
	logic                          rd_en;
	logic [AW-1:0]                 rd_addr;
	logic [ststs_pkg::KEY_W-1:0]   rd_data;

	logic [CW:0]                   mid_sum;
	logic [CW-1:0]                 mid;
	logic signed [ststs_pkg::KEY_W-1:0] skey;
	logic [CW-1:0]                 succ_j;
	logic [EW-1:0]                 cnt_e;
	logic [EW-1:0]                 rs_c;
	logic [EW-1:0]                 re_c;
	logic                          range_last;

	ststs_ram #(.DEPTH(CAPACITY)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Search midpoint, successor rank and clamped range bounds.
	always_comb begin
		mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
		mid        = mid_sum[CW:1];
		skey       = pass_q ? req_q.end_key : req_q.key;
		succ_j     = found_q ? lo_q + CW'(1) : lo_q;
		cnt_e      = EW'(count_q);
		rs_c       = (rs_q > cnt_e) ? cnt_e : rs_q;
		re_c       = (re_q > cnt_e) ? cnt_e : re_q;
		range_last = (i_q == stop_q) || (n_q == 6'(ststs_pkg::MAX_RESULTS - 1));
	end

	// Memory port control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data;
		unique case (state_q)
			S_SRD: begin
				rd_en   = lo_q < hi_q;
				rd_addr = mid[AW-1:0];
			end
			S_INS_RD: begin
				if (i_q > lo_q) begin
					rd_en   = 1'b1;
					rd_addr = AW'(i_q - CW'(1));
				end else begin
					wr_en   = 1'b1;
					wr_addr = lo_q[AW-1:0];
					wr_data = req_q.key;
				end
			end
			S_INS_WR: begin
				wr_en   = 1'b1;
				wr_addr = i_q[AW-1:0];
			end
			S_REM_RD: begin
				rd_en   = (i_q + CW'(1)) < count_q;
				rd_addr = AW'(i_q + CW'(1));
			end
			S_REM_WR: begin
				wr_en   = 1'b1;
				wr_addr = i_q[AW-1:0];
			end
			S_DISP: begin
				case (req_q.action)
					ststs_pkg::ACT_SUCC: begin
						rd_en   = succ_j < count_q;
						rd_addr = succ_j[AW-1:0];
					end
					ststs_pkg::ACT_PRED: begin
						rd_en   = lo_q != '0;
						rd_addr = AW'(lo_q - CW'(1));
					end
					ststs_pkg::ACT_FIRST: begin
						rd_en   = count_q != '0;
						rd_addr = '0;
					end
					ststs_pkg::ACT_LAST: begin
						rd_en   = count_q != '0;
						rd_addr = AW'(count_q - CW'(1));
					end
					default: ;
				endcase
			end
			S_RANGE: begin
				rd_en   = 1'b1;
				rd_addr = i_q[AW-1:0];
			end
			default: ;
		endcase
	end

	// Sequencer: search, then the action.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= 1'b0;
			pend_s1 <= 1'b0;

			// Read-and-emit stage: memory data becomes a result.
			if (pend_s1) begin
				out_v_q            <= 1'b1;
				out_q.status       <= ststs_pkg::ST_OK;
				out_q.value        <= rd_data;
				out_q.position     <= 5'(pos_s1);
				out_q.count        <= 6'(count_q);
				out_q.last_item    <= last_s1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (start && !busy) begin
						req_q   <= request;
						lo_q    <= '0;
						hi_q    <= count_q;
						found_q <= 1'b0;
						pass_q  <= 1'b0;
						state_q <= S_SRD;
					end
				end
				S_SRD: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= S_SCMP;
					end else if (!pass_q) begin
						if (req_q.action == ststs_pkg::ACT_RKEYS) begin
							rs_q    <= found_q ? EW'(lo_q) : '0;
							pass_q  <= 1'b1;
							lo_q    <= '0;
							hi_q    <= count_q;
							found_q <= 1'b0;
						end else begin
							rs_q    <= EW'(req_q.start_index);
							re_q    <= EW'(req_q.end_index);
							state_q <= S_DISP;
						end
					end else begin
						re_q    <= found_q ? EW'(lo_q) : '0;
						state_q <= S_DISP;
					end
				end
				S_SCMP: begin
					if ($signed(rd_data) < skey) begin
						lo_q <= mid_q + CW'(1);
					end else begin
						hi_q <= mid_q;
					end
					if ($signed(rd_data) == skey) begin
						found_q <= 1'b1;
					end
					state_q <= S_SRD;
				end
				S_DISP: begin
					state_q         <= S_IDLE;
					out_q.value     <= req_q.key;
					out_q.count     <= 6'(count_q);
					out_q.last_item <= 1'b1;
					out_q.position  <= '0;
					out_q.status    <= ststs_pkg::ST_MISS;
					case (req_q.action) inside
						ststs_pkg::ACT_INSERT: begin
							if (found_q) begin
								out_v_q        <= 1'b1;
								out_q.status   <= ststs_pkg::ST_OK;
								out_q.position <= 5'(lo_q);
							end else if (count_q == CW'(CAPACITY)) begin
								out_v_q      <= 1'b1;
								out_q.status <= ststs_pkg::ST_FULL;
							end else begin
								i_q     <= count_q;
								state_q <= S_INS_RD;
							end
						end
						ststs_pkg::ACT_REMOVE: begin
							if (found_q) begin
								i_q     <= lo_q;
								state_q <= S_REM_RD;
							end else begin
								out_v_q <= 1'b1;
							end
						end
						ststs_pkg::ACT_CONTAINS, ststs_pkg::ACT_RANK: begin
							out_v_q <= 1'b1;
							if (found_q) begin
								out_q.status   <= ststs_pkg::ST_OK;
								out_q.position <= 5'(lo_q);
							end
						end
						ststs_pkg::ACT_SUCC: begin
							pos_s1  <= succ_j;
							last_s1 <= 1'b1;
							if (succ_j < count_q) begin
								pend_s1 <= 1'b1;
							end else begin
								out_v_q     <= 1'b1;
								out_q.value <= '0;
							end
						end
						ststs_pkg::ACT_PRED: begin
							pos_s1  <= lo_q - CW'(1);
							last_s1 <= 1'b1;
							if (lo_q != '0) begin
								pend_s1 <= 1'b1;
							end else begin
								out_v_q     <= 1'b1;
								out_q.value <= '0;
							end
						end
						ststs_pkg::ACT_FIRST, ststs_pkg::ACT_LAST: begin
							pos_s1  <= (req_q.action == ststs_pkg::ACT_LAST) ?
								count_q - CW'(1) : '0;
							last_s1 <= 1'b1;
							if (count_q != '0) begin
								pend_s1 <= 1'b1;
							end else begin
								out_v_q     <= 1'b1;
								out_q.value <= '0;
							end
						end
						ststs_pkg::ACT_RIDX, ststs_pkg::ACT_RKEYS: begin
							if (rs_c < re_c) begin
								i_q     <= CW'(rs_c);
								stop_q  <= (re_c < cnt_e) ? CW'(re_c) : count_q - CW'(1);
								n_q     <= '0;
								state_q <= S_RANGE;
							end else begin
								out_v_q     <= 1'b1;
								out_q.value <= '0;
							end
						end
						default: begin
							out_v_q     <= 1'b1;
							out_q.value <= '0;
						end
					endcase
				end
				S_INS_RD: begin
					if (i_q > lo_q) begin
						state_q <= S_INS_WR;
					end else begin
						count_q         <= count_q + CW'(1);
						out_v_q         <= 1'b1;
						out_q.status    <= ststs_pkg::ST_OK;
						out_q.value     <= req_q.key;
						out_q.position  <= 5'(lo_q);
						out_q.count     <= 6'(count_q + CW'(1));
						out_q.last_item <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				S_INS_WR: begin
					i_q     <= i_q - CW'(1);
					state_q <= S_INS_RD;
				end
				S_REM_RD: begin
					if ((i_q + CW'(1)) < count_q) begin
						state_q <= S_REM_WR;
					end else begin
						count_q         <= count_q - CW'(1);
						out_v_q         <= 1'b1;
						out_q.status    <= ststs_pkg::ST_OK;
						out_q.value     <= req_q.key;
						out_q.position  <= 5'(lo_q);
						out_q.count     <= 6'(count_q - CW'(1));
						out_q.last_item <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				S_REM_WR: begin
					i_q     <= i_q + CW'(1);
					state_q <= S_REM_RD;
				end
				S_RANGE: begin
					pend_s1 <= 1'b1;
					pos_s1  <= i_q;
					last_s1 <= range_last;
					i_q     <= i_q + CW'(1);
					n_q     <= n_q + 6'd1;
					if (range_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE) || pend_s1;
	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule
